>>> src/countdown_timer_table_core_defines.svh
// assertion macros for the countdown timer table checker
// expects clk and rst_n in the scope of each use
`ifndef COUNTDOWN_TIMER_TABLE_CORE_DEFINES_SVH
`define COUNTDOWN_TIMER_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define CTT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("countdown timer table check failed");

// next-cycle implication
`define CTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("countdown timer table check failed");

`endif

>>> src/ctt_pkg.sv
// shared types and constants of the countdown timer table
// no dependencies
package ctt_pkg;

  localparam int unsigned FIELD_TICK_W = 16;
  localparam int unsigned FIELD_SLOT_W = 4;
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned LIMIT_W      = 5;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QFILL_W      = 2;

  typedef enum logic [1:0] {
    KIND_SPAWNED = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_FIRED   = 2'd2,
    KIND_IDLE    = 2'd3
  } ctt_kind_t;

  typedef struct packed {
    logic                    is_tick;
    logic                    periodic;
    logic [FIELD_TICK_W-1:0] ticks;
  } ctt_item_t;

  typedef struct packed {
    logic      valid;
    ctt_item_t item;
  } ctt_head_t;

  typedef struct packed {
    ctt_kind_t               kind;
    logic [FIELD_SLOT_W-1:0] slot;
    logic                    last;
  } ctt_result_t;

endpackage

>>> src/ctt_channel_ifs.sv
// valid/ready channel interfaces for items and results
// depends on ctt_pkg
interface ctt_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [ctt_pkg::FIELD_TICK_W-1:0] initial_ticks;
  logic                             periodic;
  logic [ctt_pkg::FIELD_TICK_W-1:0] tick_delta;

  modport source (output valid, op, initial_ticks, periodic, tick_delta, input ready);
  modport sink (input valid, op, initial_ticks, periodic, tick_delta, output ready);
endinterface

interface ctt_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       kind;
  logic [ctt_pkg::FIELD_SLOT_W-1:0] slot;
  logic                             last;

  modport source (output valid, kind, slot, last, input ready);
  modport sink (input valid, kind, slot, last, output ready);
endinterface

>>> src/countdown_timer_table_core.sv
// top level of the countdown timer table: front queue and back end
// depends on ctt_pkg, ctt_channel_ifs, ctt_front and ctt_back
//
//   channel  dir  beat                                           accepted when
//   in_if    in   op, initial_ticks, periodic, tick_delta        valid && ready
//   out_if   out  kind, slot, last                               valid && ready
//
// spawn: IDLE and EMIT states in the back end plus the output register, one result
// tick: list read, table read, update per active timer, plus IDLE, EMIT, output register
// a two-beat queue takes input until full while the back end works or is stalled
// out stall holds the back end in place; reset is synchronous, no clearing pass
module countdown_timer_table_core #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned TICK_WIDTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  ctt_in_if.sink    in_if,
  ctt_out_if.source out_if
);
  import ctt_pkg::*;

  ctt_head_t q_head;
  logic      q_pop;

  ctt_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .pop   (q_pop),
    .head  (q_head)
  );

  ctt_back #(
    .SLOTS      (SLOTS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .out_if (out_if)
  );

endmodule

>>> src/ctt_front.sv
// front end: accepts input beats, classifies them and queues them
// depends on ctt_pkg and ctt_in_if
module ctt_front (
  input  logic               clk,
  input  logic               rst_n,
  ctt_in_if.sink             in_if,
  input  logic               pop,
  output ctt_pkg::ctt_head_t head
);
  import ctt_pkg::*;

  ctt_item_t            entry_r [QUEUE_DEPTH];
  logic                 wr_ptr_r;
  logic                 rd_ptr_r;
  logic [QFILL_W-1:0]   fill_r;
  logic [QFILL_W-1:0]   fill_nxt;
  logic                 push;
  logic                 pop_ok;
  ctt_item_t            item_in;

  assign in_if.ready = (fill_r != QFILL_W'(QUEUE_DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign pop_ok      = pop && (fill_r != '0);

  always_comb begin
    item_in.is_tick  = in_if.op;
    item_in.periodic = in_if.op ? 1'b0 : in_if.periodic;
    item_in.ticks    = in_if.op ? in_if.tick_delta : in_if.initial_ticks;
  end

  always_comb begin
    case ({push, pop_ok})
      2'b10:   fill_nxt = fill_r + 1'b1;
      2'b01:   fill_nxt = fill_r - 1'b1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item_in;
    end
  end

  assign head.valid = (fill_r != '0);
  assign head.item  = entry_r[rd_ptr_r];

endmodule

>>> src/ctt_back.sv
// back end: timer table, list walk and result register
// depends on ctt_pkg and ctt_out_if
module ctt_back #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctt_pkg::ctt_head_t head,
  output logic               pop,
  ctt_out_if.source          out_if
);
  import ctt_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned TW = TICK_WIDTH;
  localparam logic [SW:0]   SLOTS_X  = (SW + 1)'(SLOTS);
  localparam logic [CW-1:0] CNT_FULL = CW'(SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_RD_ORDER = 5'b00010,
    ST_RD_DATA  = 5'b00100,
    ST_UPDATE   = 5'b01000,
    ST_EMIT     = 5'b10000
  } state_t;

  function automatic logic [SW-1:0] ring_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= SLOTS_X) begin
      sum = sum - SLOTS_X;
    end
    return sum[SW-1:0];
  endfunction

  function automatic logic [FIELD_SLOT_W-1:0] slot_field(input logic [SW-1:0] s);
    logic [SW+FIELD_SLOT_W-1:0] ext;
    ext = {{FIELD_SLOT_W{1'b0}}, s};
    return ext[FIELD_SLOT_W-1:0];
  endfunction

  state_t             state_r, state_nxt;
  logic [SLOTS-1:0]   active_r, active_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [SW-1:0]      head_r, head_nxt;
  logic [SW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      keep_r, keep_nxt;
  logic [TW-1:0]      elapsed_r, elapsed_nxt;
  logic [SW-1:0]      slot_r, slot_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic [SW-1:0]      hold_slot_r, hold_slot_nxt;
  logic [LIMIT_W-1:0] fired_n_r, fired_n_nxt;
  ctt_result_t        res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  ctt_result_t        out_res_r, out_res_nxt;

  logic [TW-1:0]      rem_mem [SLOTS];
  logic [TW-1:0]      rel_mem [SLOTS];
  logic [SW-1:0]      ord_mem [SLOTS];
  logic [TW-1:0]      rem_q, rel_q;
  logic [SW-1:0]      ord_q;
  logic               rem_we, rel_we, ord_we;
  logic [SW-1:0]      rem_wa, ord_wa;
  logic [TW-1:0]      rem_wd, rel_wd;
  logic [SW-1:0]      ord_wd;
  logic [SW-1:0]      ord_ra;

  logic                       free_found;
  logic [SW-1:0]              free_slot;
  logic [TW+FIELD_TICK_W-1:0] ticks_ext;
  logic [TW-1:0]              ticks_m;
  logic [TW-1:0]              init_val;
  logic [SW-1:0]              head_dec;
  logic                       out_space;
  logic                       fire;
  logic                       fire_rep;
  logic                       walk_done;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!active_r[k]) begin
        free_found = 1'b1;
        free_slot  = SW'(k);
      end
    end
  end

  assign ticks_ext = {{TW{1'b0}}, head.item.ticks};
  assign ticks_m   = ticks_ext[TW-1:0];
  assign init_val  = (ticks_m == '0) ? TW'(1) : ticks_m;
  assign head_dec  = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign out_space = !out_valid_r || out_if.ready;
  assign ord_ra    = ring_add(head_r, idx_r);
  assign fire      = (elapsed_r >= rem_q);
  assign fire_rep  = fire && (fired_n_r < LIMIT_W'(RESULT_LIMIT));
  assign walk_done = ((CW'(idx_r) + 1'b1) == count_r);

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    idx_nxt       = idx_r;
    keep_nxt      = keep_r;
    elapsed_nxt   = elapsed_r;
    slot_nxt      = slot_r;
    hold_v_nxt    = hold_v_r;
    hold_slot_nxt = hold_slot_r;
    fired_n_nxt   = fired_n_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_res_nxt   = out_res_r;
    pop           = 1'b0;
    rem_we        = 1'b0;
    rem_wa        = slot_r;
    rem_wd        = rem_q;
    rel_we        = 1'b0;
    rel_wd        = '0;
    ord_we        = 1'b0;
    ord_wa        = ring_add(head_r, keep_r[SW-1:0]);
    ord_wd        = slot_r;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.is_tick) begin
            elapsed_nxt = ticks_m;
            idx_nxt     = '0;
            keep_nxt    = '0;
            hold_v_nxt  = 1'b0;
            fired_n_nxt = '0;
            if (count_r == '0) begin
              res_nxt   = '{kind: KIND_IDLE, slot: '0, last: 1'b1};
              state_nxt = ST_EMIT;
            end else begin
              state_nxt = ST_RD_ORDER;
            end
          end else if (!free_found || count_r >= CNT_FULL) begin
            res_nxt   = '{kind: KIND_FULL, slot: '0, last: 1'b1};
            state_nxt = ST_EMIT;
          end else begin
            rem_we                = 1'b1;
            rem_wa                = free_slot;
            rem_wd                = init_val;
            rel_we                = 1'b1;
            rel_wd                = head.item.periodic ? init_val : '0;
            ord_we                = 1'b1;
            ord_wa                = head_dec;
            ord_wd                = free_slot;
            head_nxt              = head_dec;
            count_nxt             = count_r + 1'b1;
            active_nxt[free_slot] = 1'b1;
            res_nxt   = '{kind: KIND_SPAWNED, slot: slot_field(free_slot), last: 1'b1};
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_RD_ORDER: begin
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        slot_nxt  = ord_q;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!(fire_rep && hold_v_r && !out_space)) begin
          if (fire_rep) begin
            if (hold_v_r) begin
              out_valid_nxt = 1'b1;
              out_res_nxt   = '{kind: KIND_FIRED, slot: slot_field(hold_slot_r), last: 1'b0};
            end
            hold_v_nxt    = 1'b1;
            hold_slot_nxt = slot_r;
            fired_n_nxt   = fired_n_r + 1'b1;
          end
          rem_we = 1'b1;
          rem_wd = fire ? rel_q : rem_q - elapsed_r;
          if (fire && rel_q == '0) begin
            active_nxt[slot_r] = 1'b0;
          end else begin
            ord_we   = 1'b1;
            keep_nxt = keep_r + 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
          if (walk_done) begin
            count_nxt = keep_nxt;
            state_nxt = ST_EMIT;
            if (hold_v_nxt) begin
              res_nxt = '{kind: KIND_FIRED, slot: slot_field(hold_slot_nxt), last: 1'b1};
            end else begin
              res_nxt = '{kind: KIND_IDLE, slot: '0, last: 1'b1};
            end
          end else begin
            state_nxt = ST_RD_ORDER;
          end
        end
      end
      ST_EMIT: begin
        if (out_space) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      count_r     <= '0;
      head_r      <= '0;
      idx_r       <= '0;
      keep_r      <= '0;
      hold_v_r    <= 1'b0;
      fired_n_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      idx_r       <= idx_nxt;
      keep_r      <= keep_nxt;
      hold_v_r    <= hold_v_nxt;
      fired_n_r   <= fired_n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r   <= elapsed_nxt;
    slot_r      <= slot_nxt;
    hold_slot_r <= hold_slot_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
  end

  // timer storage, one write and one registered read per array
  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (rel_we) begin
      rel_mem[rem_wa] <= rel_wd;
    end
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    rem_q <= rem_mem[ord_q];
    rel_q <= rel_mem[ord_q];
    ord_q <= ord_mem[ord_ra];
  end

  assign out_if.valid = out_valid_r;
  assign out_if.kind  = out_res_r.kind;
  assign out_if.slot  = out_res_r.slot;
  assign out_if.last  = out_res_r.last;

endmodule

>>> src/ctt_checker.sv
// port-level checks of the countdown timer table result channel
// depends on ctt_pkg, ctt_channel_ifs and the defines header
`include "countdown_timer_table_core_defines.svh"

module ctt_checker (
  input logic       clk,
  input logic       rst_n,
  ctt_out_if.source out_if
);
  import ctt_pkg::*;

  `CTT_ASSERT_NEXT(a_out_hold, out_if.valid && !out_if.ready, out_if.valid)
  `CTT_ASSERT_NEXT(a_out_stable, out_if.valid && !out_if.ready, $stable(out_if.kind) && $stable(out_if.slot) && $stable(out_if.last))
  `CTT_ASSERT_NOW(a_single_last, out_if.valid && out_if.kind != KIND_FIRED, out_if.last)
  `CTT_ASSERT_NOW(a_no_slot, out_if.valid && (out_if.kind == KIND_FULL || out_if.kind == KIND_IDLE), out_if.slot == '0)

endmodule

bind countdown_timer_table_core ctt_checker u_ctt_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_if (out_if)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for countdown_timer_table_core: spawn and tick beats, random gaps
// depends on ctt_pkg, ctt_channel_ifs and the core; the scoreboard class predicts slot results
module tb_top;
  import ctt_pkg::*;

  localparam bit OP_SPAWN = 1'b0;
  localparam bit OP_TICK  = 1'b1;
  localparam int NUM_TIMERS    = 16;
  localparam int RANDOM_ITEMS  = 460;
  localparam int MAX_GAP       = 13;
  localparam int HOLD_AT_BEAT  = 60;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 80;
  localparam int CYCLE_LIMIT   = 600000;

  class timer_table_scoreboard;
    bit [15:0]   count_left[NUM_TIMERS];
    bit [15:0]   reload_ticks[NUM_TIMERS];
    bit          slot_busy[NUM_TIMERS];
    bit [3:0]    newest_first[$];
    ctt_result_t pending_results[$];
    int          mismatches;

    function new();
      mismatches = 0;
      foreach (slot_busy[s]) slot_busy[s] = 1'b0;
    endfunction

    function void apply_item(bit is_tick, bit [15:0] start_ticks, bit reloads,
                             bit [15:0] elapsed);
      ctt_result_t r;
      ctt_result_t fired[$];
      bit [3:0]    kept[$];
      bit [3:0]    s;
      bit [15:0]   t;
      int          free_slot;
      free_slot = -1;
      if (!is_tick) begin
        for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
          if (!slot_busy[k]) free_slot = k;
        end
        if (free_slot < 0) begin
          r.kind = KIND_FULL;
          r.slot = '0;
          r.last = 1'b1;
        end else begin
          s = free_slot[3:0];
          t = (start_ticks == 16'd0) ? 16'd1 : start_ticks;
          count_left[s]   = t;
          reload_ticks[s] = reloads ? t : 16'd0;
          slot_busy[s]    = 1'b1;
          newest_first.push_front(s);
          r.kind = KIND_SPAWNED;
          r.slot = s;
          r.last = 1'b1;
        end
        pending_results.push_back(r);
      end else begin
        foreach (newest_first[i]) begin
          s = newest_first[i];
          if (elapsed >= count_left[s]) begin
            r.kind = KIND_FIRED;
            r.slot = s;
            r.last = 1'b0;
            fired.push_back(r);
            if (reload_ticks[s] != 16'd0) begin
              count_left[s] = reload_ticks[s];
              kept.push_back(s);
            end else begin
              slot_busy[s] = 1'b0;
            end
          end else begin
            count_left[s] = count_left[s] - elapsed;
            kept.push_back(s);
          end
        end
        newest_first = kept;
        if (fired.size() == 0) begin
          r.kind = KIND_IDLE;
          r.slot = '0;
          r.last = 1'b1;
          pending_results.push_back(r);
        end else begin
          r = fired.pop_back();
          r.last = 1'b1;
          fired.push_back(r);
          foreach (fired[i]) pending_results.push_back(fired[i]);
        end
      end
    endfunction

    function void check_result(ctt_result_t got);
      ctt_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat kind %0d slot %0d last %0d", $time,
                 got.kind, got.slot, got.last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
          mismatches++;
        end
        if (got.slot !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   sent_count;

  ctt_in_if  in_ch();
  ctt_out_if out_ch();

  timer_table_scoreboard sb;

  countdown_timer_table_core #(
    .SLOTS(NUM_TIMERS),
    .TICK_WIDTH(16)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input bit op, input bit [15:0] start_ticks, input bit reloads,
                           input bit [15:0] elapsed);
    int gap;
    gap = ((sent_count / 40) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.initial_ticks <= start_ticks;
    in_ch.periodic      <= reloads;
    in_ch.tick_delta    <= elapsed;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.apply_item(op, start_ticks, reloads, elapsed);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic take_results();
    int          taken;
    int          gap;
    ctt_result_t got;
    taken = 0;
    forever begin
      if (taken == HOLD_AT_BEAT) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      gap = ((taken / 48) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.kind = ctt_kind_t'(out_ch.kind);
      got.slot = out_ch.slot;
      got.last = out_ch.last;
      sb.check_result(got);
      taken++;
      @(negedge clk);
    end
  endtask

  initial begin
    int        spawn_pct;
    int        pick;
    bit        op;
    bit [15:0] start_ticks;
    bit [15:0] elapsed;
    sb = new();
    sent_count = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_SPAWN;
    in_ch.initial_ticks = '0;
    in_ch.periodic = 1'b0;
    in_ch.tick_delta = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      take_results();
    join_none

    // empty table, zero count, both extremes, reload and free on one tick
    send_item(OP_TICK, 16'h0000, 1'b0, 16'h0000);
    send_item(OP_SPAWN, 16'h0000, 1'b0, 16'hffff);
    send_item(OP_SPAWN, 16'hffff, 1'b1, 16'h0000);
    send_item(OP_SPAWN, 16'h0001, 1'b1, 16'h5a5a);
    send_item(OP_TICK, 16'hffff, 1'b1, 16'h0000);
    send_item(OP_TICK, 16'h0000, 1'b0, 16'h0001);
    // fill the table, then one spawn too many
    for (int k = 0; k < 14; k++) begin
      send_item(OP_SPAWN, 16'(k * 300 + 2), (k == 3 || k == 9), 16'(k));
    end
    send_item(OP_SPAWN, 16'h1234, 1'b0, 16'h0000);
    send_item(OP_TICK, 16'h0000, 1'b0, 16'hffff);
    send_item(OP_TICK, 16'haaaa, 1'b1, 16'hffff);

    spawn_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) begin
        pick = $urandom_range(0, 2);
        spawn_pct = (pick == 0) ? 85 : (pick == 1) ? 50 : 20;
      end
      op = ($urandom_range(0, 99) >= spawn_pct) ? OP_TICK : OP_SPAWN;
      pick = $urandom_range(0, 9);
      start_ticks = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'($urandom) :
                    (pick == 2) ? 16'hffff : 16'($urandom_range(1, 400));
      pick = $urandom_range(0, 9);
      elapsed = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'($urandom) :
                (pick == 2) ? 16'hffff : 16'($urandom_range(0, 150));
      send_item(op, start_ticks, ($urandom_range(0, 32) == 0), elapsed);
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+src
src/ctt_pkg.sv
src/ctt_channel_ifs.sv
src/ctt_front.sv
src/ctt_back.sv
src/countdown_timer_table_core.sv
src/ctt_checker.sv
tb/sv/tb_top.sv
